@@ hdl/gtda_pkg.sv @@
`default_nettype none
package gtda_pkg;

    // field widths
    localparam int unsigned LAT_W      = 31;
    localparam int unsigned LON_W      = 32;
    localparam int unsigned SEC_W      = 17;
    localparam int unsigned STEP_W     = 21;
    localparam int unsigned SPEED_W    = 17;
    localparam int unsigned TOTAL_W    = 48;
    localparam int unsigned AVG_W      = 32;
    localparam int unsigned GATE_W     = 21;
    localparam int unsigned FLOOR_W    = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 21;

    // datapath widths
    localparam int unsigned ANG_W      = 34;
    localparam int unsigned ACC_W      = 36;
    localparam int unsigned CRD_W      = 40;
    localparam int unsigned CRD_ITERS  = 30;
    localparam int unsigned CRD_CNT_W  = 5;
    localparam int unsigned MUL_W      = 32;
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned SQ_W       = 62;
    localparam int unsigned ROOT_W     = 31;
    localparam int unsigned DIV_NUM_W  = 54;
    localparam int unsigned DIV_DEN_W  = 27;
    localparam int unsigned DIV_CNT_W  = 6;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [CRD_W-1:0]  t_crd;
    typedef logic [CRD_CNT_W-1:0]     t_crd_cnt;
    typedef logic [MUL_W-1:0]         t_mul;
    typedef logic [PROD_W-1:0]        t_prod;
    typedef logic [SQ_W-1:0]          t_sqv;
    typedef logic [ROOT_W-1:0]        t_root;
    typedef logic [DIV_NUM_W-1:0]     t_num;
    typedef logic [DIV_DEN_W-1:0]     t_den;
    typedef logic [DIV_CNT_W-1:0]     t_div_cnt;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_FLOOR = 2'd2;

    localparam logic [GATE_W-1:0]  LOW_GATE_RST  = 21'd1000;
    localparam logic [GATE_W-1:0]  HIGH_GATE_RST = 21'd2000000;
    localparam logic [FLOOR_W-1:0] AVG_FLOOR_RST = 20'd200;

    // constants; the pi, half pi, gain and one values are Q2.30
    localparam t_crd  PI_Q30      = 40'sd3373259426;
    localparam t_crd  HALF_PI_Q30 = 40'sd1686629713;
    localparam t_crd  CRD_GAIN    = 40'sd652032874;
    localparam t_acc  ONE_Q30     = 36'sd1073741824;
    localparam t_mul  ANGLE_K     = 32'd2012227627;
    localparam t_mul  EARTH2_CM   = 32'd1273400000;
    localparam t_ang  HALF_TURN   = 34'sd1800000000;
    localparam t_ang  FULL_TURN   = 34'sd3600000000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};

    // reciprocal of 1000, exact for dividends below 2^27
    localparam t_mul        SPD_RECIP = 32'd137438954;
    localparam int unsigned SPD_SHIFT = 37;

    typedef enum logic [1:0] {
        CRD_ROTATE,
        CRD_VECTOR
    } t_crd_mode;

    typedef struct packed {
        logic      start;
        t_crd_mode mode;
    } t_crd_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ANG_MUL,
        S_ANG_CRD,
        S_ANG_WAIT,
        S_HAV_MUL,
        S_HAV_ACC,
        S_SQY_GO,
        S_SQY_WAIT,
        S_SQX_GO,
        S_SQX_WAIT,
        S_VEC_GO,
        S_VEC_WAIT,
        S_DIST_MUL,
        S_DIST_RND,
        S_SPD_GO,
        S_SPD_WAIT,
        S_AVG_GO,
        S_AVG_WAIT,
        S_OUT
    } t_state;

    // arctangent of 2^-i in Q2.30
    function automatic logic [29:0] atan_q30(input t_crd_cnt i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/gtda_if.sv @@
`default_nettype none
interface gtda_fix_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [gtda_pkg::LAT_W-1:0]   fix_lat;
    logic signed [gtda_pkg::LON_W-1:0]   fix_lon;
    logic [gtda_pkg::SEC_W-1:0]          elapsed_seconds;

    modport source (output valid, cmd, fix_lat, fix_lon, elapsed_seconds, input ready);
    modport sink   (input valid, cmd, fix_lat, fix_lon, elapsed_seconds, output ready);
endinterface

interface gtda_res_if;
    logic                            valid;
    logic                            ready;
    logic [gtda_pkg::STEP_W-1:0]     step_distance_cm;
    logic [gtda_pkg::SPEED_W-1:0]    speed_milli;
    logic [gtda_pkg::TOTAL_W-1:0]    total_distance_cm;
    logic [gtda_pkg::AVG_W-1:0]      avg_speed_milli;

    modport source (output valid, step_distance_cm, speed_milli, total_distance_cm,
                    avg_speed_milli, input ready);
    modport sink   (input valid, step_distance_cm, speed_milli, total_distance_cm,
                    avg_speed_milli, output ready);
endinterface

interface gtda_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gtda_pkg::CFG_IDX_W-1:0]     index;
    logic [gtda_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/gtda_mul.sv @@
`default_nettype none
module gtda_mul (
    input  wire logic           i_clk,
    input  wire gtda_pkg::t_mul i_a,
    input  wire gtda_pkg::t_mul i_b,
    output gtda_pkg::t_prod     o_p
);
    gtda_pkg::t_prod r_p;

    // one registered 32x32 product
    always_ff @(posedge i_clk) begin
        r_p <= gtda_pkg::t_prod'(i_a) * gtda_pkg::t_prod'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

@@ hdl/gtda_cordic.sv @@
`default_nettype none
module gtda_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gtda_pkg::t_crd_cmd i_cmd,
    input  wire gtda_pkg::t_crd     i_x,
    input  wire gtda_pkg::t_crd     i_y,
    input  wire gtda_pkg::t_crd     i_z,
    output gtda_pkg::t_crd          o_x,
    output gtda_pkg::t_crd          o_y,
    output gtda_pkg::t_crd          o_z,
    output logic                    o_done
);
    localparam gtda_pkg::t_crd_cnt LAST = gtda_pkg::t_crd_cnt'(gtda_pkg::CRD_ITERS - 1);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic               r_vec;
    gtda_pkg::t_crd_cnt r_i;
    gtda_pkg::t_crd     r_x;
    gtda_pkg::t_crd     r_y;
    gtda_pkg::t_crd     r_z;

    gtda_pkg::t_crd     w_dx;
    gtda_pkg::t_crd     w_dy;
    gtda_pkg::t_crd     w_at;
    logic               w_pos;

    always_comb begin
        w_dx  = r_y >>> r_i;
        w_dy  = r_x >>> r_i;
        w_at  = gtda_pkg::t_crd'(gtda_pkg::atan_q30(r_i));
        // rotate toward z = 0, or vector toward y = 0
        w_pos = r_vec ? !(r_y > 0) : (r_z >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_vec  <= (i_cmd.mode == gtda_pkg::CRD_VECTOR);
                r_x    <= i_x;
                r_y    <= i_y;
                // fold angles beyond a quarter turn
                if (i_cmd.mode == gtda_pkg::CRD_ROTATE && i_z > gtda_pkg::HALF_PI_Q30) begin
                    r_z   <= i_z - gtda_pkg::PI_Q30;
                    r_neg <= 1'b1;
                end else if (i_cmd.mode == gtda_pkg::CRD_ROTATE &&
                             i_z < -gtda_pkg::HALF_PI_Q30) begin
                    r_z   <= i_z + gtda_pkg::PI_Q30;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= i_z;
                    r_neg <= 1'b0;
                end
            end else if (r_busy) begin
                if (w_pos) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_z;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ hdl/gtda_isqrt.sv @@
`default_nettype none
module gtda_isqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire gtda_pkg::t_sqv i_v,
    output gtda_pkg::t_root     o_root,
    output logic                o_done
);
    // operands never exceed 2^(SQ_W-2)
    localparam gtda_pkg::t_sqv TOP_BIT = gtda_pkg::t_sqv'(1) << (gtda_pkg::SQ_W - 2);

    logic           r_busy;
    logic           r_done;
    gtda_pkg::t_sqv r_v;
    gtda_pkg::t_sqv r_r;
    gtda_pkg::t_sqv r_bit;
    gtda_pkg::t_sqv w_sum;

    assign w_sum = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_v;
                r_r    <= '0;
                r_bit  <= TOP_BIT;
            end else if (r_busy) begin
                if (r_v >= w_sum) begin
                    r_v <= r_v - w_sum;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_r[gtda_pkg::ROOT_W-1:0];
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ hdl/gtda_div.sv @@
`default_nettype none
module gtda_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire gtda_pkg::t_num i_num,
    input  wire gtda_pkg::t_den i_den,
    output gtda_pkg::t_num      o_quo,
    output logic                o_done
);
    localparam gtda_pkg::t_div_cnt LAST = gtda_pkg::t_div_cnt'(gtda_pkg::DIV_NUM_W - 1);

    logic                         r_busy;
    logic                         r_done;
    gtda_pkg::t_div_cnt           r_cnt;
    gtda_pkg::t_num               r_q;
    gtda_pkg::t_den               r_rem;
    gtda_pkg::t_den               r_den;
    logic [gtda_pkg::DIV_DEN_W:0] w_t;
    logic                         w_ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        w_t  = {r_rem, r_q[gtda_pkg::DIV_NUM_W-1]};
        w_ge = (w_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? gtda_pkg::t_den'(w_t - {1'b0, r_den})
                              : w_t[gtda_pkg::DIV_DEN_W-1:0];
                r_q   <= {r_q[gtda_pkg::DIV_NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ hdl/gps_trip_distance_accumulator.sv @@
// channel  | dir | payload                                            | transaction when
// ---------+-----+----------------------------------------------------+-----------------
// i_cfg    | in  | index, data                                        | valid & ready
// i_fix    | in  | cmd, fix_lat, fix_lon, elapsed_seconds             | valid & ready
// o_res    | out | step_distance_cm, speed_milli, total_distance_cm,  | valid & ready
//          |     | avg_speed_milli                                    |
//
// a distance fix runs four cordic rotations, two square roots, one cordic vectoring,
// the speed as a reciprocal multiply and one average division (skipped with zero
// seconds), all in sequence on single shared units
// a reset command or the first fix after reset goes straight to the output register
// without any calculation, and the sequencer then returns to idle for the next fix
// i_rst_n is synchronous; it resets the sequencer, trip state and configuration registers
// i_fix is taken only while the sequencer is idle; a finished result waits in the
// output register while the next fix is accepted, and a stalled o_res holds the
// sequencer in its last state until the register frees up
// i_cfg is always ready
`default_nettype none
module gps_trip_distance_accumulator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gtda_cfg_if.sink    i_cfg,
    gtda_fix_if.sink    i_fix,
    gtda_res_if.source  o_res
);
    // angle loop order
    localparam logic [1:0] K_DLAT = 2'd0;
    localparam logic [1:0] K_DLON = 2'd1;
    localparam logic [1:0] K_LAT1 = 2'd2;
    localparam logic [1:0] K_LAT2 = 2'd3;

    localparam logic [gtda_pkg::ROOT_W-1:0] ROOT_ONE = 31'd1073741824;

    gtda_pkg::t_state r_state, n_state;

    // configuration registers
    logic [gtda_pkg::GATE_W-1:0]  r_low_gate;
    logic [gtda_pkg::GATE_W-1:0]  r_high_gate;
    logic [gtda_pkg::FLOOR_W-1:0] r_avg_floor;

    // trip state
    logic signed [gtda_pkg::LAT_W-1:0] r_prev_lat;
    logic signed [gtda_pkg::LON_W-1:0] r_prev_lon;
    logic [gtda_pkg::TOTAL_W-1:0]      r_total;
    logic                              r_have_fix;

    // working registers
    logic signed [gtda_pkg::LAT_W-1:0] r_cur_lat;
    logic signed [gtda_pkg::LON_W-1:0] r_cur_lon;
    logic [gtda_pkg::SEC_W-1:0]        r_sec;
    logic [1:0]                        r_k;
    logic                              r_neg;
    gtda_pkg::t_ang                    r_sl, r_sn, r_c1, r_c2, r_t1, r_t2;
    gtda_pkg::t_acc                    r_acc;
    logic [gtda_pkg::ROOT_W-1:0]       r_a;
    gtda_pkg::t_root                   r_yr, r_xr;
    gtda_pkg::t_mul                    r_z;
    logic [gtda_pkg::STEP_W-1:0]       r_step;
    logic [gtda_pkg::SPEED_W-1:0]      r_speed;
    logic [gtda_pkg::AVG_W-1:0]        r_avg;

    // output register
    logic                              r_ov;
    logic [gtda_pkg::STEP_W-1:0]       r_o_step;
    logic [gtda_pkg::SPEED_W-1:0]      r_o_speed;
    logic [gtda_pkg::TOTAL_W-1:0]      r_o_total;
    logic [gtda_pkg::AVG_W-1:0]        r_o_avg;

    // shared units
    gtda_pkg::t_mul     w_mul_a, w_mul_b;
    gtda_pkg::t_prod    w_prod;
    gtda_pkg::t_crd_cmd w_crd_cmd;
    gtda_pkg::t_crd     w_crd_x0, w_crd_y0, w_crd_z0;
    gtda_pkg::t_crd     w_crd_x, w_crd_y, w_crd_z;
    logic               w_crd_done;
    logic               w_sq_start;
    gtda_pkg::t_sqv     w_sq_v;
    gtda_pkg::t_root    w_sq_root;
    logic               w_sq_done;
    logic               w_div_start;
    gtda_pkg::t_num     w_div_num;
    gtda_pkg::t_den     w_div_den;
    gtda_pkg::t_num     w_div_quo;
    logic               w_div_done;

    // datapath helpers
    logic               w_in_acc;
    logic               w_out_ld;
    gtda_pkg::t_ang     w_u, w_uw;
    logic               w_u_neg;
    gtda_pkg::t_prod    w_rnd;
    gtda_pkg::t_crd     w_angle;
    gtda_pkg::t_ang     w_hav_a, w_hav_b;
    gtda_pkg::t_acc     w_q, w_sum;
    logic [33:0]        w_dist;
    logic [gtda_pkg::TOTAL_W-1:0] w_room;
    logic [gtda_pkg::AVG_W-1:0]   w_avg_sat;

    function automatic gtda_pkg::t_mul mag_of(input gtda_pkg::t_ang v);
        gtda_pkg::t_ang m;
        m = v[gtda_pkg::ANG_W-1] ? -v : v;
        return m[gtda_pkg::MUL_W-1:0];
    endfunction

    assign w_in_acc    = i_fix.valid && i_fix.ready;
    assign w_out_ld    = (r_state == gtda_pkg::S_OUT) && (!r_ov || o_res.ready);
    assign i_fix.ready = (r_state == gtda_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_gate  <= gtda_pkg::LOW_GATE_RST;
            r_high_gate <= gtda_pkg::HIGH_GATE_RST;
            r_avg_floor <= gtda_pkg::AVG_FLOOR_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gtda_pkg::REG_LOW_GATE) begin
                r_low_gate <= i_cfg.data;
            end else if (i_cfg.index == gtda_pkg::REG_HIGH_GATE) begin
                r_high_gate <= i_cfg.data;
            end else if (i_cfg.index == gtda_pkg::REG_AVG_FLOOR) begin
                r_avg_floor <= i_cfg.data[gtda_pkg::FLOOR_W-1:0];
            end
        end
    end

    // angle source, wrapped into one half turn either way
    always_comb begin
        unique case (r_k)
            K_DLAT:  w_u = gtda_pkg::t_ang'(r_cur_lat) - gtda_pkg::t_ang'(r_prev_lat);
            K_DLON:  w_u = gtda_pkg::t_ang'(r_cur_lon) - gtda_pkg::t_ang'(r_prev_lon);
            K_LAT1:  w_u = gtda_pkg::t_ang'(r_prev_lat);
            default: w_u = gtda_pkg::t_ang'(r_cur_lat);
        endcase
        priority if (w_u > gtda_pkg::HALF_TURN) begin
            w_uw = w_u - gtda_pkg::FULL_TURN;
        end else if (w_u < -gtda_pkg::HALF_TURN) begin
            w_uw = w_u + gtda_pkg::FULL_TURN;
        end else begin
            w_uw = w_u;
        end
        w_u_neg = w_uw[gtda_pkg::ANG_W-1];
    end

    // haversine product operands
    always_comb begin
        unique case (r_k)
            2'd0:    begin w_hav_a = r_sl; w_hav_b = r_sl; end
            2'd1:    begin w_hav_a = r_c1; w_hav_b = r_c2; end
            2'd2:    begin w_hav_a = r_sn; w_hav_b = r_sn; end
            default: begin w_hav_a = r_t1; w_hav_b = r_t2; end
        endcase
    end

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            gtda_pkg::S_ANG_MUL: begin
                w_mul_a = mag_of(w_uw);
                w_mul_b = gtda_pkg::ANGLE_K;
            end
            gtda_pkg::S_HAV_MUL: begin
                w_mul_a = mag_of(w_hav_a);
                w_mul_b = mag_of(w_hav_b);
            end
            gtda_pkg::S_DIST_MUL: begin
                w_mul_a = r_z;
                w_mul_b = gtda_pkg::EARTH2_CM;
            end
            gtda_pkg::S_SPD_GO: begin
                // step * 36 + 500, then divided by 1000 through the reciprocal
                w_mul_a = (gtda_pkg::t_mul'(r_step) << 5) + (gtda_pkg::t_mul'(r_step) << 2)
                        + gtda_pkg::t_mul'(500);
                w_mul_b = gtda_pkg::SPD_RECIP;
            end
            default: ;
        endcase
    end

    // product post-processing
    always_comb begin
        // differences are half angles
        w_rnd   = r_k[1] ? ((w_prod + gtda_pkg::t_prod'(64'd536870912)) >> 30)
                         : ((w_prod + gtda_pkg::t_prod'(64'd1073741824)) >> 31);
        w_angle = r_neg ? -gtda_pkg::t_crd'(w_rnd[gtda_pkg::MUL_W-1:0])
                        :  gtda_pkg::t_crd'(w_rnd[gtda_pkg::MUL_W-1:0]);
        w_q     = gtda_pkg::t_acc'({2'b00, w_prod[gtda_pkg::PROD_W-1:30]});
        w_q     = r_neg ? -w_q : w_q;
        w_sum   = r_acc + w_q;
        w_dist  = w_prod[63:30] + {33'd0, w_prod[29]};
        w_room  = gtda_pkg::TOTAL_MAX - r_total;
        w_avg_sat = (|w_div_quo[gtda_pkg::DIV_NUM_W-1:gtda_pkg::AVG_W])
                  ? gtda_pkg::AVG_MAX : w_div_quo[gtda_pkg::AVG_W-1:0];
    end

    // shared unit commands
    always_comb begin
        w_crd_cmd.start = 1'b0;
        w_crd_cmd.mode  = gtda_pkg::CRD_ROTATE;
        w_crd_x0        = gtda_pkg::CRD_GAIN;
        w_crd_y0        = '0;
        w_crd_z0        = w_angle;
        w_sq_start      = 1'b0;
        w_sq_v          = gtda_pkg::t_sqv'({r_a, 30'd0});
        w_div_start     = 1'b0;
        w_div_num       = '0;
        w_div_den       = '0;
        unique case (r_state)
            gtda_pkg::S_ANG_CRD: begin
                w_crd_cmd.start = 1'b1;
            end
            gtda_pkg::S_SQY_GO: begin
                w_sq_start = 1'b1;
            end
            gtda_pkg::S_SQX_GO: begin
                w_sq_start = 1'b1;
                w_sq_v     = gtda_pkg::t_sqv'({ROOT_ONE - r_a, 30'd0});
            end
            gtda_pkg::S_VEC_GO: begin
                w_crd_cmd.start = 1'b1;
                w_crd_cmd.mode  = gtda_pkg::CRD_VECTOR;
                w_crd_x0        = gtda_pkg::t_crd'(r_xr);
                w_crd_y0        = gtda_pkg::t_crd'(r_yr);
                w_crd_z0        = '0;
            end
            gtda_pkg::S_AVG_GO: begin
                w_div_start = (r_sec != '0);
                w_div_num   = (gtda_pkg::t_num'(r_total) << 5) + (gtda_pkg::t_num'(r_total) << 2)
                            + gtda_pkg::t_num'(r_sec) * gtda_pkg::t_num'(500);
                w_div_den   = gtda_pkg::t_den'(r_sec) * gtda_pkg::t_den'(1000);
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtda_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_fix.cmd || !r_have_fix) ? gtda_pkg::S_OUT
                                                         : gtda_pkg::S_ANG_MUL;
                end
            end
            gtda_pkg::S_ANG_MUL:  n_state = gtda_pkg::S_ANG_CRD;
            gtda_pkg::S_ANG_CRD:  n_state = gtda_pkg::S_ANG_WAIT;
            gtda_pkg::S_ANG_WAIT: begin
                if (w_crd_done) begin
                    n_state = (r_k == K_LAT2) ? gtda_pkg::S_HAV_MUL : gtda_pkg::S_ANG_MUL;
                end
            end
            gtda_pkg::S_HAV_MUL:  n_state = gtda_pkg::S_HAV_ACC;
            gtda_pkg::S_HAV_ACC:  n_state = (r_k == 2'd3) ? gtda_pkg::S_SQY_GO
                                                           : gtda_pkg::S_HAV_MUL;
            gtda_pkg::S_SQY_GO:   n_state = gtda_pkg::S_SQY_WAIT;
            gtda_pkg::S_SQY_WAIT: if (w_sq_done) n_state = gtda_pkg::S_SQX_GO;
            gtda_pkg::S_SQX_GO:   n_state = gtda_pkg::S_SQX_WAIT;
            gtda_pkg::S_SQX_WAIT: if (w_sq_done) n_state = gtda_pkg::S_VEC_GO;
            gtda_pkg::S_VEC_GO:   n_state = gtda_pkg::S_VEC_WAIT;
            gtda_pkg::S_VEC_WAIT: if (w_crd_done) n_state = gtda_pkg::S_DIST_MUL;
            gtda_pkg::S_DIST_MUL: n_state = gtda_pkg::S_DIST_RND;
            gtda_pkg::S_DIST_RND: n_state = gtda_pkg::S_SPD_GO;
            gtda_pkg::S_SPD_GO:   n_state = gtda_pkg::S_SPD_WAIT;
            gtda_pkg::S_SPD_WAIT: n_state = gtda_pkg::S_AVG_GO;
            gtda_pkg::S_AVG_GO:   n_state = (r_sec == '0) ? gtda_pkg::S_OUT
                                                          : gtda_pkg::S_AVG_WAIT;
            gtda_pkg::S_AVG_WAIT: if (w_div_done) n_state = gtda_pkg::S_OUT;
            gtda_pkg::S_OUT:      if (w_out_ld) n_state = gtda_pkg::S_IDLE;
            default:              n_state = gtda_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // trip state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lat <= '0;
            r_prev_lon <= '0;
            r_total    <= '0;
            r_have_fix <= 1'b0;
        end else begin
            unique case (r_state)
                gtda_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_cur_lat <= i_fix.fix_lat;
                        r_cur_lon <= i_fix.fix_lon;
                        r_sec     <= i_fix.elapsed_seconds;
                        r_k       <= K_DLAT;
                        r_step    <= '0;
                        r_speed   <= '0;
                        r_avg     <= '0;
                        // a reset command also clears the total; it and a first fix only load the position
                        if (i_fix.cmd) begin
                            r_total <= '0;
                        end
                        r_have_fix <= 1'b1;
                    end
                end
                gtda_pkg::S_ANG_MUL: begin
                    r_neg <= w_u_neg;
                end
                gtda_pkg::S_ANG_WAIT: begin
                    if (w_crd_done) begin
                        unique case (r_k)
                            K_DLAT:  r_sl <= gtda_pkg::t_ang'(w_crd_y);
                            K_DLON:  r_sn <= gtda_pkg::t_ang'(w_crd_y);
                            K_LAT1:  r_c1 <= gtda_pkg::t_ang'(w_crd_x);
                            default: r_c2 <= gtda_pkg::t_ang'(w_crd_x);
                        endcase
                        r_k <= r_k + 1'b1;
                    end
                end
                gtda_pkg::S_HAV_MUL: begin
                    r_neg <= w_hav_a[gtda_pkg::ANG_W-1] ^ w_hav_b[gtda_pkg::ANG_W-1];
                end
                gtda_pkg::S_HAV_ACC: begin
                    unique case (r_k)
                        2'd0:    r_acc <= w_q;
                        2'd1:    r_t1  <= gtda_pkg::t_ang'(w_q);
                        2'd2:    r_t2  <= gtda_pkg::t_ang'(w_q);
                        default: begin
                            // clamp a into [0, 1]
                            priority if (w_sum < 0) begin
                                r_a <= '0;
                            end else if (w_sum > gtda_pkg::ONE_Q30) begin
                                r_a <= ROOT_ONE;
                            end else begin
                                r_a <= w_sum[gtda_pkg::ROOT_W-1:0];
                            end
                        end
                    endcase
                    r_k <= r_k + 1'b1;
                end
                gtda_pkg::S_SQY_WAIT: if (w_sq_done) r_yr <= w_sq_root;
                gtda_pkg::S_SQX_WAIT: if (w_sq_done) r_xr <= w_sq_root;
                gtda_pkg::S_VEC_WAIT: begin
                    if (w_crd_done) begin
                        r_z <= (w_crd_z < 0) ? '0 : w_crd_z[gtda_pkg::MUL_W-1:0];
                    end
                end
                gtda_pkg::S_DIST_RND: begin
                    // gate out steps too short or too long
                    if (w_dist < {13'd0, r_low_gate} || w_dist > {13'd0, r_high_gate}) begin
                        r_step <= '0;
                    end else begin
                        r_step <= w_dist[gtda_pkg::STEP_W-1:0];
                    end
                end
                gtda_pkg::S_SPD_WAIT: begin
                    r_speed <= w_prod[gtda_pkg::SPD_SHIFT +: gtda_pkg::SPEED_W];
                    r_total <= (w_room < gtda_pkg::TOTAL_W'(r_step))
                             ? gtda_pkg::TOTAL_MAX
                             : r_total + gtda_pkg::TOTAL_W'(r_step);
                end
                gtda_pkg::S_AVG_GO: begin
                    // zero seconds: zero or saturated
                    if (r_sec == '0) begin
                        r_avg <= (r_total == '0) ? '0 : gtda_pkg::AVG_MAX;
                    end
                end
                gtda_pkg::S_AVG_WAIT: begin
                    if (w_div_done) begin
                        r_avg <= (w_avg_sat < gtda_pkg::AVG_W'(r_avg_floor)) ? '0 : w_avg_sat;
                    end
                end
                gtda_pkg::S_OUT: begin
                    if (w_out_ld) begin
                        r_prev_lat <= r_cur_lat;
                        r_prev_lon <= r_cur_lon;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_ld) begin
            r_ov      <= 1'b1;
            r_o_step  <= r_step;
            r_o_speed <= r_speed;
            r_o_total <= r_total;
            r_o_avg   <= r_avg;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_res.valid             = r_ov;
    assign o_res.step_distance_cm  = r_o_step;
    assign o_res.speed_milli       = r_o_speed;
    assign o_res.total_distance_cm = r_o_total;
    assign o_res.avg_speed_milli   = r_o_avg;

    gtda_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    gtda_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_crd_cmd),
        .i_x     (w_crd_x0),
        .i_y     (w_crd_y0),
        .i_z     (w_crd_z0),
        .o_x     (w_crd_x),
        .o_y     (w_crd_y),
        .o_z     (w_crd_z),
        .o_done  (w_crd_done)
    );

    gtda_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_v     (w_sq_v),
        .o_root  (w_sq_root),
        .o_done  (w_sq_done)
    );

    gtda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );
endmodule
`default_nettype wire

@@ hdl/gtda_checker.sv @@
`default_nettype none
module gtda_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [gtda_pkg::STEP_W-1:0]       step,
    input wire logic [gtda_pkg::SPEED_W-1:0]      speed,
    input wire logic [gtda_pkg::TOTAL_W-1:0]      total,
    input wire logic [gtda_pkg::AVG_W-1:0]        avg
);
    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total) && $stable(avg))
        else $error("result changed while stalled");

    // busy right after a transaction is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // an empty trip has no step and no average
    a_empty_trip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && total == '0 |-> step == '0 && avg == '0)
        else $error("nonzero step or average with zero total");

    // no step, no speed
    a_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && step == '0 |-> speed == '0)
        else $error("speed without step");
endmodule

bind gps_trip_distance_accumulator gtda_checker u_gtda_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_fix.valid),
    .in_ready  (i_fix.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .step      (o_res.step_distance_cm),
    .speed     (o_res.speed_milli),
    .total     (o_res.total_distance_cm),
    .avg       (o_res.avg_speed_milli)
);
`default_nettype wire
